/* rtl/core/tssc_pkg.sv */
// ----------------------------------------------------------------------------
// tssc_pkg
// Shared constants, codes and types of the typed shadow store unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tssc_pkg;

	// Store geometry.
	localparam int STORE_WORDS = 64;
	localparam int WORD_AW     = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

	// Action codes.
	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_POLL  = 2'd2;
	localparam logic [1:0] ACT_LIVE  = 2'd3;

	// Data type codes.
	localparam logic [2:0] TYP_BIT  = 3'd0;
	localparam logic [2:0] TYP_BYTE = 3'd1;
	localparam logic [2:0] TYP_HALF = 3'd2;
	localparam logic [2:0] TYP_WORD = 3'd3;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	// Read lengths in bytes.
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_BIT  = 3'd1;
	localparam logic [2:0] LEN_BYTE = 3'd1;
	localparam logic [2:0] LEN_HALF = 3'd2;
	localparam logic [2:0] LEN_WORD = 3'd4;

	// Slice masks.
	localparam logic [31:0] MASK_BIT  = 32'h0000_0001;
	localparam logic [31:0] MASK_BYTE = 32'h0000_00FF;
	localparam logic [31:0] MASK_HALF = 32'h0000_FFFF;
	localparam logic [31:0] MASK_WORD = 32'hFFFF_FFFF;

	// Decoded slice of one command.
	typedef struct packed {
		logic [15:0] word;
		logic [4:0]  shift;
		logic [31:0] mask;
		logic [31:0] wmask;
		logic [2:0]  len;
		logic [1:0]  status;
		logic        is_bit;
	} slice_t;

endpackage

`default_nettype wire

/* rtl/core/tssc_ram.sv */
// ----------------------------------------------------------------------------
// tssc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tssc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire                                       clk,
	input  wire                                       we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                          wdata,
	input  wire                                       re,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/tssc_decode.sv */
// ----------------------------------------------------------------------------
// tssc_decode
// Turns action, type and index into word index, shift, masks and status.
// ----------------------------------------------------------------------------
`default_nettype none

module tssc_decode (
	input  wire  [1:0]           action,
	input  wire  [2:0]           data_type,
	input  wire  [15:0]          item_index,
	output tssc_pkg::slice_t     slice
);

	logic [2:0] eff_type;

	// A live update always addresses a whole word.
	assign eff_type = (action == tssc_pkg::ACT_LIVE) ? tssc_pkg::TYP_WORD : data_type;

	always_comb begin
		slice        = '0;
		slice.status = tssc_pkg::ST_OK;
		case (eff_type)
			tssc_pkg::TYP_BIT: begin
				slice.word   = {5'd0, item_index[15:5]};
				slice.shift  = item_index[4:0];
				slice.mask   = tssc_pkg::MASK_BIT;
				slice.len    = tssc_pkg::LEN_BIT;
				slice.is_bit = 1'b1;
			end
			tssc_pkg::TYP_BYTE: begin
				slice.word  = {2'd0, item_index[15:2]};
				slice.shift = {item_index[1:0], 3'b000};
				slice.mask  = tssc_pkg::MASK_BYTE;
				slice.len   = tssc_pkg::LEN_BYTE;
			end
			tssc_pkg::TYP_HALF: begin
				slice.word  = {1'b0, item_index[15:1]};
				slice.shift = {item_index[0], 4'b0000};
				slice.mask  = tssc_pkg::MASK_HALF;
				slice.len   = tssc_pkg::LEN_HALF;
			end
			tssc_pkg::TYP_WORD: begin
				slice.word = item_index;
				slice.mask = tssc_pkg::MASK_WORD;
				slice.len  = tssc_pkg::LEN_WORD;
			end
			default: begin
				slice.status = tssc_pkg::ST_INVALID;
			end
		endcase
		if (slice.status == tssc_pkg::ST_OK &&
		    slice.word >= 16'(tssc_pkg::STORE_WORDS)) begin
			slice.status = tssc_pkg::ST_RANGE;
		end
		slice.wmask = slice.mask << slice.shift;
	end

endmodule

`default_nettype wire

/* rtl/core/typed_shadow_store_change_detect_unit.sv */
// ----------------------------------------------------------------------------
// typed_shadow_store_change_detect_unit
// Live and shadow word stores with typed read, write, poll and live update.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Fields
// command   in         start / busy       action, data_type, item_index, write_value
// result    out        done (one cycle)   read_value, read_length, changed, status
//
// A word is accepted on a rising edge with start high and busy low. The next
// cycle the two memories return the addressed word, the slice is read,
// modified and written back, and the result word is registered; done is high
// in the cycle after that. Busy is high while a word waits on the memory read
// ahead of its write-back, so a new word is taken only after that write-back.
// The receiver cannot stall. After reset both stores read as zero at once
// through a valid bit per entry; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_shadow_store_change_detect_unit (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          start,
	output logic         busy,
	input  wire  [1:0]   action,
	input  wire  [2:0]   data_type,
	input  wire  [15:0]  item_index,
	input  wire  [31:0]  write_value,
	output logic         done,
	output logic [31:0]  read_value,
	output logic [2:0]   read_length,
	output logic         changed,
	output logic [1:0]   status
);

	localparam int AW = tssc_pkg::WORD_AW;
	localparam int NW = tssc_pkg::STORE_WORDS;

	logic              accept;
	tssc_pkg::slice_t  dec;

	logic              valid_s1;
	tssc_pkg::slice_t  slice_s1;
	logic [1:0]        act_s1;
	logic [31:0]       val_s1;
	logic              live_vld_s1;
	logic              shd_vld_s1;

	logic [NW-1:0]     live_vld_q;
	logic [NW-1:0]     shd_vld_q;

	logic [31:0]       live_rdata;
	logic [31:0]       shd_rdata;
	logic [31:0]       lv;
	logic [31:0]       sv;
	logic [31:0]       nv;

	logic              live_we;
	logic              shd_we;
	logic [31:0]       live_wdata;
	logic [31:0]       shd_wdata;
	logic [AW-1:0]     wr_addr;
	logic              ok_s1;

	logic [31:0]       rval;
	logic [2:0]        rlen;
	logic              chg;

	logic              done_q;
	logic [31:0]       read_value_q;
	logic [2:0]        read_length_q;
	logic              changed_q;
	logic [1:0]        status_q;

	assign busy   = valid_s1;
	assign accept = start && !busy;

	tssc_decode u_decode (
		.action     (action),
		.data_type  (data_type),
		.item_index (item_index),
		.slice      (dec)
	);

	tssc_ram #(.WIDTH(32), .DEPTH(NW)) u_live_ram (
		.clk   (clk),
		.we    (live_we),
		.waddr (wr_addr),
		.wdata (live_wdata),
		.re    (accept),
		.raddr (dec.word[AW-1:0]),
		.rdata (live_rdata)
	);

	tssc_ram #(.WIDTH(32), .DEPTH(NW)) u_shadow_ram (
		.clk   (clk),
		.we    (shd_we),
		.waddr (wr_addr),
		.wdata (shd_wdata),
		.re    (accept),
		.raddr (dec.word[AW-1:0]),
		.rdata (shd_rdata)
	);

	// Stage 1 command capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slice_s1    <= dec;
			act_s1      <= action;
			val_s1      <= write_value;
			live_vld_s1 <= live_vld_q[dec.word[AW-1:0]];
			shd_vld_s1  <= shd_vld_q[dec.word[AW-1:0]];
		end
	end

	// Entries never written since reset read as zero.
	assign lv      = live_vld_s1 ? live_rdata : 32'd0;
	assign sv      = shd_vld_s1 ? shd_rdata : 32'd0;
	assign ok_s1   = valid_s1 && (slice_s1.status == tssc_pkg::ST_OK);
	assign wr_addr = slice_s1.word[AW-1:0];

	always_comb begin
		live_we    = 1'b0;
		shd_we     = 1'b0;
		live_wdata = lv;
		shd_wdata  = sv;
		rval       = 32'd0;
		rlen       = tssc_pkg::LEN_NONE;
		chg        = 1'b0;
		// A bit write sets the bit when the low byte of the value is nonzero.
		nv = (slice_s1.is_bit ? {31'd0, |val_s1[7:0]} : (val_s1 & slice_s1.mask))
		     << slice_s1.shift;
		if (ok_s1) begin
			case (act_s1)
				tssc_pkg::ACT_READ: begin
					rval      = (lv >> slice_s1.shift) & slice_s1.mask;
					rlen      = slice_s1.len;
					shd_we    = 1'b1;
					shd_wdata = (sv & ~slice_s1.wmask) | (lv & slice_s1.wmask);
				end
				tssc_pkg::ACT_WRITE: begin
					live_we    = 1'b1;
					shd_we     = 1'b1;
					live_wdata = (lv & ~slice_s1.wmask) | nv;
					shd_wdata  = (sv & ~slice_s1.wmask) | nv;
				end
				tssc_pkg::ACT_POLL: begin
					chg = (lv & slice_s1.wmask) != (sv & slice_s1.wmask);
				end
				default: begin
					live_we    = 1'b1;
					live_wdata = val_s1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_vld_q <= '0;
			shd_vld_q  <= '0;
			done_q     <= 1'b0;
		end else begin
			if (live_we) begin
				live_vld_q[wr_addr] <= 1'b1;
			end
			if (shd_we) begin
				shd_vld_q[wr_addr] <= 1'b1;
			end
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			read_value_q  <= rval;
			read_length_q <= rlen;
			changed_q     <= chg;
			status_q      <= slice_s1.status;
		end
	end

	assign done        = done_q;
	assign read_value  = read_value_q;
	assign read_length = read_length_q;
	assign changed     = changed_q;
	assign status      = status_q;

	// A result word follows exactly one busy cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding busy cycle");

	// Each word is in work for a single cycle.
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	// An accepted command always enters the memory stage.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not enter stage 1");

	// Failed commands return no payload.
	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != tssc_pkg::ST_OK) |->
		(read_value == 32'd0 && read_length == tssc_pkg::LEN_NONE && !changed))
		else $error("payload returned with an error status");

	// Stores are never written for a failed command.
	a_no_write_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(live_we || shd_we) |-> (valid_s1 && slice_s1.status == tssc_pkg::ST_OK))
		else $error("store written for a failed command");

endmodule

`default_nettype wire

/* sim/typed_shadow_store_change_detect_unit_tb.sv */
// ----------------------------------------------------------------------------
// typed_shadow_store_change_detect_unit_tb
// Self-checking bench for the live/shadow word store unit. A directed set hits
// the type and index extremes, every action and each status. A long random
// run follows that concentrates on a few hot words so that reads, writes,
// polls and live updates interact. Every accepted word is predicted on its own
// copy of both stores, and each result is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_shadow_store_change_detect_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS  = 925;
	localparam int CALM_TAIL     = 150;
	localparam int CYCLE_LIMIT   = 100000;
	localparam int DRAIN_CYCLES  = 10;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  data_type;
		logic [15:0] item_index;
		logic [31:0] write_value;
	} access_cmd_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [2:0]  read_length;
		logic        changed;
		logic [1:0]  status;
	} access_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  action = '0;
	logic [2:0]  data_type = '0;
	logic [15:0] item_index = '0;
	logic [31:0] write_value = '0;
	wire         busy;
	wire         done;
	wire  [31:0] read_value;
	wire  [2:0]  read_length;
	wire         changed;
	wire  [1:0]  status;

	access_cmd_t    pending_cmds[$];
	access_result_t outcomes_due[$];
	logic [31:0]    live_copy[tssc_pkg::STORE_WORDS];
	logic [31:0]    shadow_copy[tssc_pkg::STORE_WORDS];

	int errors = 0;
	int cycles = 0;
	int accepted = 0;
	int results_seen = 0;
	int calm_from = 0;
	int gap_left = 0;
	bit gaps_on = 1'b1;
	int act_count[4] = '{default: 0};
	int status_count[3] = '{default: 0};
	int changed_count = 0;

	typed_shadow_store_change_detect_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.data_type   (data_type),
		.item_index  (item_index),
		.write_value (write_value),
		.done        (done),
		.read_value  (read_value),
		.read_length (read_length),
		.changed     (changed),
		.status      (status)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Applies one access to the local copies of both stores and returns the
	// result that the unit must report for it.
	function automatic access_result_t apply_access(access_cmd_t c);
		access_result_t r;
		logic [2:0]     kind;
		logic [15:0]    w;
		logic [4:0]     sh;
		logic [31:0]    m;
		logic [31:0]    wm;
		logic [31:0]    lv;
		logic [31:0]    sv;
		logic [31:0]    nv;
		logic [2:0]     len;
		r = '0;
		w = '0;
		sh = '0;
		m = '0;
		len = tssc_pkg::LEN_NONE;
		kind = (c.action == tssc_pkg::ACT_LIVE) ? tssc_pkg::TYP_WORD : c.data_type;
		case (kind)
			tssc_pkg::TYP_BIT: begin
				w = c.item_index >> 5;
				sh = c.item_index[4:0];
				m = tssc_pkg::MASK_BIT;
				len = tssc_pkg::LEN_BIT;
			end
			tssc_pkg::TYP_BYTE: begin
				w = c.item_index >> 2;
				sh = {c.item_index[1:0], 3'b000};
				m = tssc_pkg::MASK_BYTE;
				len = tssc_pkg::LEN_BYTE;
			end
			tssc_pkg::TYP_HALF: begin
				w = c.item_index >> 1;
				sh = {c.item_index[0], 4'b0000};
				m = tssc_pkg::MASK_HALF;
				len = tssc_pkg::LEN_HALF;
			end
			tssc_pkg::TYP_WORD: begin
				w = c.item_index;
				m = tssc_pkg::MASK_WORD;
				len = tssc_pkg::LEN_WORD;
			end
			default: r.status = tssc_pkg::ST_INVALID;
		endcase
		if (r.status == tssc_pkg::ST_OK && w >= tssc_pkg::STORE_WORDS)
			r.status = tssc_pkg::ST_RANGE;
		if (r.status == tssc_pkg::ST_OK) begin
			wm = m << sh;
			lv = live_copy[w[tssc_pkg::WORD_AW-1:0]];
			sv = shadow_copy[w[tssc_pkg::WORD_AW-1:0]];
			case (c.action)
				tssc_pkg::ACT_READ: begin
					r.read_value = (lv >> sh) & m;
					r.read_length = len;
					shadow_copy[w[tssc_pkg::WORD_AW-1:0]] = (sv & ~wm) | (lv & wm);
				end
				tssc_pkg::ACT_WRITE: begin
					// A bit write takes the whole low byte as its truth value.
					if (kind == tssc_pkg::TYP_BIT)
						nv = (c.write_value[7:0] != 8'h00) ? 32'd1 : 32'd0;
					else
						nv = c.write_value & m;
					nv = nv << sh;
					live_copy[w[tssc_pkg::WORD_AW-1:0]] = (lv & ~wm) | nv;
					shadow_copy[w[tssc_pkg::WORD_AW-1:0]] = (sv & ~wm) | nv;
				end
				tssc_pkg::ACT_POLL: r.changed = ((lv & wm) != (sv & wm));
				default: live_copy[w[tssc_pkg::WORD_AW-1:0]] = c.write_value;
			endcase
		end
		return r;
	endfunction

	task automatic queue_cmd(input logic [1:0] a, input logic [2:0] t,
			input logic [15:0] i, input logic [31:0] v);
		access_cmd_t c;
		c.action = a;
		c.data_type = t;
		c.item_index = i;
		c.write_value = v;
		pending_cmds.push_back(c);
	endtask

	task automatic queue_directed();
		queue_cmd(tssc_pkg::ACT_READ,  tssc_pkg::TYP_WORD, 16'd0,    32'h0000_0000);
		queue_cmd(tssc_pkg::ACT_WRITE, tssc_pkg::TYP_WORD, 16'd63,   32'hFFFF_FFFF);
		queue_cmd(tssc_pkg::ACT_READ,  tssc_pkg::TYP_BIT,  16'd2047, 32'h0000_0000);
		queue_cmd(tssc_pkg::ACT_WRITE, tssc_pkg::TYP_BYTE, 16'd255,  32'h1234_56A5);
		queue_cmd(tssc_pkg::ACT_WRITE, tssc_pkg::TYP_HALF, 16'd127,  32'hFFFF_8001);
		queue_cmd(tssc_pkg::ACT_READ,  tssc_pkg::TYP_HALF, 16'd127,  32'h0000_0000);
		// A bit write with a zero low byte clears, even with upper bits set.
		queue_cmd(tssc_pkg::ACT_WRITE, tssc_pkg::TYP_BIT,  16'd0,    32'hFFFF_FF00);
		queue_cmd(tssc_pkg::ACT_WRITE, tssc_pkg::TYP_BIT,  16'd1,    32'h0000_0080);
		queue_cmd(tssc_pkg::ACT_READ,  tssc_pkg::TYP_BYTE, 16'd0,    32'h0000_0000);
		// Live updates ignore the type field, even an unsupported one.
		queue_cmd(tssc_pkg::ACT_LIVE,  3'd7,               16'd5,    32'hDEAD_BEEF);
		queue_cmd(tssc_pkg::ACT_POLL,  tssc_pkg::TYP_WORD, 16'd5,    32'h0000_0000);
		queue_cmd(tssc_pkg::ACT_POLL,  tssc_pkg::TYP_BIT,  16'd160,  32'h0000_0000);
		queue_cmd(tssc_pkg::ACT_READ,  tssc_pkg::TYP_HALF, 16'd10,   32'h0000_0000);
		queue_cmd(tssc_pkg::ACT_POLL,  tssc_pkg::TYP_HALF, 16'd10,   32'h0000_0000);
		queue_cmd(tssc_pkg::ACT_POLL,  tssc_pkg::TYP_HALF, 16'd11,   32'h0000_0000);
		queue_cmd(tssc_pkg::ACT_READ,  3'd4,               16'd0,    32'h0000_0000);
		queue_cmd(tssc_pkg::ACT_WRITE, 3'd5,               16'd3,    32'hA5A5_A5A5);
		// Invalid type wins over an index that is also out of range.
		queue_cmd(tssc_pkg::ACT_POLL,  3'd7,               16'hFFFF, 32'h0000_0000);
		queue_cmd(tssc_pkg::ACT_READ,  tssc_pkg::TYP_BIT,  16'd2048, 32'h0000_0000);
		queue_cmd(tssc_pkg::ACT_WRITE, tssc_pkg::TYP_BYTE, 16'd256,  32'h0000_00FF);
		queue_cmd(tssc_pkg::ACT_POLL,  tssc_pkg::TYP_HALF, 16'd128,  32'h0000_0000);
		queue_cmd(tssc_pkg::ACT_READ,  tssc_pkg::TYP_WORD, 16'hFFFF, 32'h0000_0000);
		queue_cmd(tssc_pkg::ACT_LIVE,  tssc_pkg::TYP_BIT,  16'd64,   32'h5555_AAAA);
		queue_cmd(tssc_pkg::ACT_LIVE,  tssc_pkg::TYP_WORD, 16'd63,   32'h0000_0000);
		queue_cmd(tssc_pkg::ACT_POLL,  tssc_pkg::TYP_WORD, 16'd63,   32'h0000_0000);
	endtask

	// Random words cluster on a small, changing set of hot words so that
	// live updates, reads and polls on the same slices follow one another.
	task automatic queue_random(input int count);
		int          hot[4];
		int          w;
		int          roll;
		int          idx;
		logic [1:0]  a;
		logic [2:0]  t;
		logic [31:0] v;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				for (int k = 0; k < 4; k++)
					hot[k] = $urandom_range(0, tssc_pkg::STORE_WORDS - 1);
			end
			a = 2'($urandom_range(0, 3));
			t = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(4, 7)) :
				3'($urandom_range(0, 3));
			roll = $urandom_range(0, 19);
			if (roll == 0)
				w = -1;
			else if (roll == 1)
				w = tssc_pkg::STORE_WORDS + $urandom_range(0, 3);
			else if (roll < 15)
				w = hot[$urandom_range(0, 3)];
			else
				w = $urandom_range(0, tssc_pkg::STORE_WORDS - 1);
			if (w < 0)
				idx = $urandom_range(0, 65535);
			else if (a == tssc_pkg::ACT_LIVE)
				idx = w;
			else begin
				case (t)
					tssc_pkg::TYP_BIT:  idx = w * 32 + $urandom_range(0, 31);
					tssc_pkg::TYP_BYTE: idx = w * 4 + $urandom_range(0, 3);
					tssc_pkg::TYP_HALF: idx = w * 2 + $urandom_range(0, 1);
					default:            idx = w;
				endcase
			end
			roll = $urandom_range(0, 15);
			if (roll == 0)
				v = 32'h0000_0000;
			else if (roll == 1)
				v = 32'hFFFF_FFFF;
			else if (roll < 4)
				v = {24'($urandom_range(0, 32'hFF_FFFF)), 8'h00};
			else
				v = $urandom;
			queue_cmd(a, t, idx[15:0], v);
		end
	endtask

	// Sender: one word at a time, with random gaps outside the calm tail.
	always @(posedge clk) begin : sender
		access_cmd_t nxt;
		bit          taken;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				outcomes_due.push_back(apply_access({action, data_type, item_index,
						write_value}));
				act_count[action]++;
				accepted++;
				if ($urandom_range(0, 39) == 0)
					gaps_on = !gaps_on;
				if (gaps_on && accepted < calm_from && $urandom_range(0, 2) == 0)
					gap_left = $urandom_range(1, 5);
			end
			if (!start || taken) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					nxt = pending_cmds.pop_front();
					action <= nxt.action;
					data_type <= nxt.data_type;
					item_index <= nxt.item_index;
					write_value <= nxt.write_value;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string field, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$realtime, field, exp_v, act_v);
			errors++;
		end
	endtask

	// Results last one cycle and cannot be held off.
	always @(posedge clk) begin : result_check
		access_result_t exp_r;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (outcomes_due.size() == 0) begin
				$display("%0t: stray result, expected none, actual value 0x%0h status %0d",
					$realtime, read_value, status);
				errors++;
			end else begin
				exp_r = outcomes_due.pop_front();
				check_field("read_value", exp_r.read_value, read_value);
				check_field("read_length", 32'(exp_r.read_length), 32'(read_length));
				check_field("changed", 32'(exp_r.changed), 32'(changed));
				check_field("status", 32'(exp_r.status), 32'(status));
				if (exp_r.status <= tssc_pkg::ST_RANGE)
					status_count[exp_r.status]++;
				if (exp_r.changed)
					changed_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycles, outcomes_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < tssc_pkg::STORE_WORDS; k++) begin
			live_copy[k] = '0;
			shadow_copy[k] = '0;
		end
		queue_directed();
		queue_random(RANDOM_WORDS);
		calm_from = pending_cmds.size() - CALM_TAIL;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_cmds.size() != 0 || start || outcomes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d commands: %0d reads, %0d writes, %0d polls, %0d live updates.",
			accepted, act_count[tssc_pkg::ACT_READ], act_count[tssc_pkg::ACT_WRITE],
			act_count[tssc_pkg::ACT_POLL], act_count[tssc_pkg::ACT_LIVE]);
		$display("%0d results; ok %0d, invalid type %0d, out of range %0d; changes seen %0d.",
			results_seen, status_count[tssc_pkg::ST_OK],
			status_count[tssc_pkg::ST_INVALID], status_count[tssc_pkg::ST_RANGE],
			changed_count);
		if (errors == 0 && outcomes_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
rtl/core/tssc_pkg.sv
rtl/core/tssc_ram.sv
rtl/core/tssc_decode.sv
rtl/core/typed_shadow_store_change_detect_unit.sv
sim/typed_shadow_store_change_detect_unit_tb.sv
